[rtl/core/ftoa_pkg.sv]
// Shared types, constants and helpers for the float to decimal text core.
`default_nettype none
package ftoa_pkg;
    localparam int CHAR_W = 8;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;
    localparam int INT_DIGITS = 10;

    // Power of ten table for fraction scaling.
    function automatic logic [29:0] pow_ten(input logic [3:0] n);
        case (n)
            4'd0: pow_ten = 30'd1;
            4'd1: pow_ten = 30'd10;
            4'd2: pow_ten = 30'd100;
            4'd3: pow_ten = 30'd1000;
            4'd4: pow_ten = 30'd10000;
            4'd5: pow_ten = 30'd100000;
            4'd6: pow_ten = 30'd1000000;
            4'd7: pow_ten = 30'd10000000;
            4'd8: pow_ten = 30'd100000000;
            4'd9: pow_ten = 30'd1000000000;
            default: pow_ten = 30'd1;
        endcase
    endfunction

    // Control bundle carried with a number through the serializer.
    typedef struct packed {
        logic       neg;
        logic       ovf;
        logic [3:0] nd;
        logic [3:0] fd;
    } ftoa_ctl_t;
endpackage
`default_nettype wire

[rtl/core/float_to_decimal_ascii_core.sv]
// Top level: float to fixed-decimal ASCII text, one character per output word.
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tdata[31:0] value_bits
//  m_axis  | out | tdata[7:0] char_code, tlast last_char, tuser[0] overflow
//  cfg     | in  | cfg_wdata[2:0] frac_digits
//
// Front end is a three stage pipeline: decode, fraction multiply, shift.
// The serializer loads a number while idle, then sends one word a cycle while
// the output is not stalled; a number has 1..18 characters. The front end
// stalls as a whole while stage 3 holds a number that the serializer has not
// taken; no word is lost or repeated.
// Reset clears all valid bits and frac_digits.
`default_nettype none
module float_to_decimal_ascii_core
    import ftoa_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire  [2:0] cfg_wdata,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [31:0] s_axis_tdata,   // [31:0] value_bits
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_code
    output logic       m_axis_tlast,   // last_char
    output logic [0:0] m_axis_tuser    // [0] overflow
);
    localparam logic [3:0] MAXD = 4'(MAX_FRAC_DIGITS);

    logic [2:0] frac_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) frac_reg <= '0;
        else if (cfg_we) frac_reg <= cfg_wdata;
    end

    logic adv;
    // ---- stage 1: decode
    logic        v1_reg;
    logic        neg1_reg, ovf1_reg;
    logic [30:0] ip1_reg;
    logic [23:0] fb1_reg;   // fraction bits, left aligned at sh
    logic [7:0]  sh1_reg;
    logic [3:0]  fd1_reg;
    logic        fz1_reg;   // fraction is zero by construction

    logic [7:0]  ex;
    logic [23:0] m;
    logic [7:0]  e_sh;
    logic [3:0]  d_now;
    always_comb begin
        ex = s_axis_tdata[30:23];
        m = (ex == 8'd0) ? {1'b0, s_axis_tdata[22:0]} : {1'b1, s_axis_tdata[22:0]};
        d_now = ({1'b0, frac_reg} > MAXD) ? MAXD : {1'b0, frac_reg};
        // sh = 23 - e = 150 - ex (ex>=1), 149 for subnormals
        e_sh = (ex == 8'd0) ? 8'd149 : 8'(8'd150 - ex);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg1_reg <= s_axis_tdata[31] && (s_axis_tdata[30:0] != 31'd0);
            fd1_reg  <= d_now;
            ovf1_reg <= 1'b0;
            fz1_reg  <= 1'b0;
            ip1_reg  <= '0;
            fb1_reg  <= '0;
            sh1_reg  <= e_sh;
            if (ex == 8'hFF || ex >= 8'd158) begin
                ovf1_reg <= 1'b1;
                ip1_reg  <= INT_SAT;
                fz1_reg  <= 1'b1;
            end else if (ex >= 8'd150) begin
                ip1_reg <= 31'({7'd0, m} << (ex - 8'd150));
                fz1_reg <= 1'b1;
            end else if (ex >= 8'd127) begin
                ip1_reg <= 31'({7'd0, m} >> e_sh);
                fb1_reg <= m & ((24'd1 << e_sh) - 24'd1);
            end else begin
                fb1_reg <= m;
            end
        end
    end

    // ---- stage 2: fraction times 10^d (24 x 30)
    logic        v2_reg, neg2_reg, ovf2_reg;
    logic [30:0] ip2_reg;
    logic [53:0] prod2_reg;
    logic [7:0]  sh2_reg;
    logic [3:0]  fd2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg2_reg <= neg1_reg; ovf2_reg <= ovf1_reg; ip2_reg <= ip1_reg;
            sh2_reg <= sh1_reg; fd2_reg <= fd1_reg;
            prod2_reg <= fz1_reg ? 54'd0 : 54'(fb1_reg) * 54'(pow_ten(fd1_reg));
        end
    end

    // ---- stage 3: shift down to get the fraction value
    logic        v3_reg, neg3_reg, ovf3_reg;
    logic [30:0] ip3_reg;
    logic [29:0] fv3_reg;
    logic [3:0]  fd3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg3_reg <= neg2_reg; ovf3_reg <= ovf2_reg; ip3_reg <= ip2_reg;
            fd3_reg <= fd2_reg;
            fv3_reg <= (sh2_reg >= 8'd60) ? 30'd0 : 30'(prod2_reg >> sh2_reg);
        end
    end

    // ---- serializer: digits are peeled by dividing by powers of ten,
    // one parallel compare-subtract per digit position, a digit a cycle unless the output stalls.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SIGN  = 5'b00010,
        S_INT   = 5'b00100,
        S_DOT   = 5'b01000,
        S_FRAC  = 5'b10000
    } st_t;

    function automatic st_t ctl_next_st(input logic n);
        ctl_next_st = n ? S_SIGN : S_INT;
    endfunction

    st_t         st_reg, st_next;
    ftoa_ctl_t   ctl_reg;
    logic [30:0] irem_reg;
    logic [29:0] frem_reg;
    logic [3:0]  pos_reg;   // current digit position (power index)
    logic [3:0]  nd_calc;
    logic [3:0]  dig;
    logic [31:0] ipw;
    logic [30:0] rem_sub;
    logic        last_c;

    // digit count of the integer part
    always_comb begin
        nd_calc = 4'd1;
        for (int k = 1; k < INT_DIGITS; k++) begin
            if ({1'b0, ip3_reg} >= 32'(pow_ten(4'(k)))) nd_calc = 4'(k + 1);
        end
    end

    // one digit: value / 10^pos for value < 10^(pos+1), by up to 9 subtracts
    // against a single power, done as a small parallel compare set.
    logic [33:0] mul_k [10];
    always_comb begin
        ipw = (st_reg == S_FRAC) ? 32'(pow_ten(pos_reg)) : 32'(pow_ten(pos_reg));
        dig = 4'd0;
        for (int k = 1; k < 10; k++) begin
            mul_k[k] = 34'(ipw) * 34'(k);
        end
        mul_k[0] = '0;
        for (int k = 1; k < 10; k++) begin
            if (st_reg == S_FRAC) begin
                if (34'(frem_reg) >= mul_k[k]) dig = 4'(k);
            end else if (34'(irem_reg) >= mul_k[k]) dig = 4'(k);
        end
        rem_sub = 31'(34'(irem_reg) - mul_k[dig]);
    end

    logic out_full;
    logic take;
    assign out_full = m_axis_tvalid && !m_axis_tready;
    // the serializer loads only when its output word is not stalled
    assign take = (st_reg == S_IDLE) && v3_reg && !out_full;
    // front pipeline moves when stage 3 is empty or being taken
    assign adv = !v3_reg || take;
    assign s_axis_tready = adv;

    always_comb begin
        st_next = st_reg;
        last_c = 1'b0;
        case (st_reg)
            S_SIGN: st_next = S_INT;
            S_INT: begin
                if (pos_reg == 4'd0) begin
                    if (ctl_reg.fd != 4'd0) st_next = S_DOT;
                    else begin st_next = S_IDLE; last_c = 1'b1; end
                end
            end
            S_DOT: st_next = S_FRAC;
            S_FRAC: begin
                if (pos_reg == 4'd0) begin st_next = S_IDLE; last_c = 1'b1; end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            m_axis_tvalid <= 1'b0;
        end else if (!out_full) begin
            m_axis_tvalid <= 1'b0;
            if (st_reg == S_IDLE) begin
                if (v3_reg) st_reg <= ctl_next_st(neg3_reg);
            end else begin
                m_axis_tvalid <= 1'b1;
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_full) begin
            if (st_reg == S_IDLE) begin
                if (v3_reg) begin
                    ctl_reg.neg <= neg3_reg;
                    ctl_reg.ovf <= ovf3_reg;
                    ctl_reg.nd  <= nd_calc;
                    ctl_reg.fd  <= fd3_reg;
                    irem_reg <= ip3_reg;
                    frem_reg <= fv3_reg;
                    pos_reg  <= 4'(nd_calc - 4'd1);
                end
            end else begin
                m_axis_tuser[0] <= ctl_reg.ovf;
                m_axis_tlast <= last_c;
                case (st_reg)
                    S_SIGN: m_axis_tdata <= CH_MINUS;
                    S_INT: begin
                        m_axis_tdata <= CH_ZERO + 8'(dig);
                        irem_reg <= rem_sub;
                        if (pos_reg == 4'd0) pos_reg <= 4'(ctl_reg.fd - 4'd1);
                        else pos_reg <= pos_reg - 4'd1;
                    end
                    S_DOT: m_axis_tdata <= CH_DOT;
                    S_FRAC: begin
                        m_axis_tdata <= CH_ZERO + 8'(dig);
                        frem_reg <= 30'(34'(frem_reg) - mul_k[dig]);
                        if (pos_reg != 4'd0) pos_reg <= pos_reg - 4'd1;
                    end
                    default: m_axis_tdata <= CH_ZERO;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/ftoa_checker.sv]
// Port-level checker for the float to decimal text core, bound to the top level.
`default_nettype none
module ftoa_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire       m_axis_tlast,
    input wire [0:0] m_axis_tuser
);
    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");
    // only legal characters
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata == 8'h2D || m_axis_tdata == 8'h2E ||
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39)))
        else $error("bad character");
    // a dot is never the final word
    a_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata == 8'h2E |-> !m_axis_tlast)
        else $error("dot ends number");
    // overflow flag is steady within one number
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tuser == $past(m_axis_tuser))
        else $error("overflow changed within number");
endmodule

bind float_to_decimal_ascii_core ftoa_checker u_ftoa_checker (
    .aclk(aclk), .aresetn(aresetn), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the float to decimal text core: predicts each number's characters and checks them.
`timescale 1ns / 100ps
`default_nettype none

class text_scoreboard;
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       ovf;
    } char_t;

    char_t pending[$];
    int    errors;
    int    chars_seen;
    int    numbers_seen;
    int    ovf_numbers;
    int    neg_numbers;

    // Works out the text of one number at the given digit count.
    function void note_number(logic [31:0] bits, logic [2:0] digits);
        logic        neg;
        logic [7:0]  expf;
        logic [23:0] m;
        logic        ovf;
        logic [31:0] ipart;
        logic [63:0] fval;
        logic [63:0] fb;
        logic [63:0] scale;
        int          e;
        int          sh;
        int          d;
        int          nd;
        int          total;
        int          k;
        int          i;
        logic [7:0]  digs[10];
        logic [63:0] p;
        char_t       c;

        neg = bits[31];
        expf = bits[30:23];
        d = (digits > ftoa_pkg::INT_DIGITS) ? 0 : digits;
        if (d > 6) d = 6;
        ovf = 0;
        ipart = 0;
        fval = 0;
        scale = 1;
        for (i = 0; i < d; i++) scale = scale * 10;
        if (expf == 8'hFF) begin
            ovf = 1;
            ipart = ftoa_pkg::INT_SAT;
        end else begin
            if (expf == 0) begin
                m = {1'b0, bits[22:0]};
                e = -126;
            end else begin
                m = {1'b1, bits[22:0]};
                e = int'(expf) - 127;
            end
            if (e >= 31) begin
                ovf = 1;
                ipart = ftoa_pkg::INT_SAT;
            end else if (e >= 23) begin
                ipart = 32'(64'(m) << (e - 23));
            end else begin
                sh = 23 - e;
                if (sh < 60) begin
                    fb = 64'(m) & ((64'd1 << sh) - 1);
                    ipart = 32'(64'(m) >> sh);
                    fval = (fb * scale) >> sh;
                end
            end
        end
        if (bits[30:0] == 0) neg = 0;
        nd = 0;
        do begin
            digs[nd] = ftoa_pkg::CH_ZERO + 8'(ipart % 10);
            nd++;
            ipart = ipart / 10;
        end while (ipart != 0 && nd < 10);
        total = neg + nd + (d != 0 ? 1 + d : 0);
        k = 0;
        if (neg) begin
            k++;
            c = '{ftoa_pkg::CH_MINUS, k == total, ovf};
            pending.push_back(c);
        end
        for (i = nd - 1; i >= 0; i--) begin
            k++;
            c = '{digs[i], k == total, ovf};
            pending.push_back(c);
        end
        if (d != 0) begin
            k++;
            c = '{ftoa_pkg::CH_DOT, k == total, ovf};
            pending.push_back(c);
            for (i = d - 1; i >= 0; i--) begin
                p = 1;
                repeat (i) p = p * 10;
                k++;
                c = '{ftoa_pkg::CH_ZERO + 8'((fval / p) % 10), k == total, ovf};
                pending.push_back(c);
            end
        end
        numbers_seen++;
        if (ovf) ovf_numbers++;
        if (neg) neg_numbers++;
    endfunction

    function void check_char(logic [7:0] code, logic last, logic ovf);
        char_t x;
        chars_seen++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word code=%h last=%b ovf=%b", $time, code, last, ovf);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (x.code !== code) begin
            $display("%0t: char mismatch exp=%h act=%h", $time, x.code, code);
            errors++;
        end
        if (x.last !== last) begin
            $display("%0t: last mismatch exp=%b act=%b", $time, x.last, last);
            errors++;
        end
        if (x.ovf !== ovf) begin
            $display("%0t: overflow mismatch exp=%b act=%b", $time, x.ovf, ovf);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    text_scoreboard sb = new();
    logic [2:0] digits_now = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    longint     cycles = 0;
    logic       phase_any_fail;

    float_to_decimal_ascii_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random stall, check each accepted word
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // valid stays high between back-to-back words; idle cycles drop it
    task automatic send_word(logic [31:0] bits);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= bits;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_number(bits, digits_now);
    endtask

    task automatic set_digits(logic [2:0] v);
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        digits_now = v;
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(5))
            0: b[30:23] = 8'($urandom_range(100, 160));
            1: b[30:23] = 8'($urandom_range(118, 130));
            2: b[30:23] = 8'($urandom_range(150, 160));
            3: b[30:23] = ($urandom_range(1)) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return b;
    endfunction

    logic [31:0] directed[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h3F00_0000, 32'hBF00_0000, 32'h4049_0FDB, 32'hC2F6_E979,
        32'h4EFF_FFFF, 32'h4F00_0000, 32'hCF00_0000, 32'h7F80_0000,
        32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h807F_FFFF, 32'h7F7F_FFFF, 32'h3F7F_FFFF, 32'h4B7F_FFFF,
        32'h3DCC_CCCD, 32'h4CBE_BC20
    };

    int sizes[3] = '{30, 46, 0};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed[i]) send_word(directed[i]);
        set_digits(6);
        foreach (directed[i]) send_word(directed[i]);
        set_digits(7); // above the cap, behaves as six
        send_word(32'h4049_0FDB);
        send_word(32'hC0A0_0001);
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = sizes[ph];
            recv_idle = (ph == 0) ? 46 : (ph == 1) ? 30 : 0;
            for (int dsel = 0; dsel < 4; dsel++) begin
                set_digits(3'(ph == 2 && dsel == 3 ? 0 : $urandom_range(7)));
                repeat (36) send_word(rand_float());
            end
        end
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d numbers, %0d characters; %0d negative, %0d saturated",
                 sb.numbers_seen, sb.chars_seen, sb.neg_numbers, sb.ovf_numbers);
        phase_any_fail = (sb.errors != 0) || (sb.pending.size() != 0);
        if (!phase_any_fail)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
